/* rtl/qjt_pkg.sv */
`default_nettype none
package qjt_pkg;

	localparam int JOINTS = 4;
	localparam int JW     = 2;

	// Q1.30 one, and the bit-serial unit sizes
	localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
	localparam logic [63:0] HALF_Q30 = 64'h0000_0000_2000_0000;
	localparam int DIV_W   = 62;
	localparam int MUL_AW  = 33;
	localparam int MUL_BW  = 31;

	// Configuration register indexes
	localparam logic [1:0] REG_TILT   = 2'd0;
	localparam logic [1:0] REG_COORD  = 2'd1;
	localparam logic [1:0] REG_SPEED  = 2'd2;
	localparam logic [1:0] REG_PERIOD = 2'd3;

	// Input function codes
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	// Return codes
	localparam logic [1:0] RET_INIT = 2'd0;
	localparam logic [1:0] RET_RUN  = 2'd1;
	localparam logic [1:0] RET_OK   = 2'd2;

	typedef struct packed {
		logic               func;
		logic signed [31:0] init_q1;
		logic signed [31:0] init_q2;
		logic signed [31:0] init_q3;
		logic signed [31:0] init_q4;
	} qjt_in_t;

	typedef struct packed {
		logic signed [31:0] pose_q1;
		logic signed [31:0] pose_q2;
		logic signed [31:0] pose_q3;
		logic signed [31:0] pose_q4;
		logic [31:0]        total_duration;
		logic               moving;
		logic [1:0]         action_ret;
	} qjt_out_t;

endpackage
`default_nettype wire

/* rtl/qjt_div.sv */
`default_nettype none
module qjt_div import qjt_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [31:0]      divisor,
	output logic                  done,
	output logic [DIV_W-1:0]      quot
);

	logic [31:0]      rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [31:0]      dvs_q;
	logic [5:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [33:0]      trial;

	// Try subtracting the divisor from the shifted remainder
	assign trial = {1'b0, rem_q, quo_q[DIV_W-1]} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// One quotient bit per cycle, restoring
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= trial[33] ? {rem_q[30:0], quo_q[DIV_W-1]} : trial[31:0];
			quo_q <= {quo_q[DIV_W-2:0], ~trial[33]};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule
`default_nettype wire

/* rtl/qjt_mul.sv */
`default_nettype none
module qjt_mul import qjt_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [MUL_AW-1:0] a,
	input  wire logic [MUL_BW-1:0] b,
	output logic                   done,
	output logic [63:0]            prod
);

	logic [MUL_AW:0]   acc_q;
	logic [MUL_BW-1:0] lo_q;
	logic [MUL_AW-1:0] a_q;
	logic [4:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [MUL_AW:0]   sum;

	assign sum = acc_q + (lo_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'(MUL_BW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift-add, one multiplier bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			lo_q  <= b;
			a_q   <= a;
		end else if (busy_q) begin
			acc_q <= {1'b0, sum[MUL_AW:1]};
			lo_q  <= {sum[0], lo_q[MUL_BW-1:1]};
		end
	end

	assign done = done_q;
	assign prod = {acc_q[MUL_AW-1:0], lo_q};

endmodule
`default_nettype wire

/* rtl/quintic_joint_trajectory.sv */
// A start item runs one 62-step serial divide per joint, none where the speed is zero.
// A tick in motion runs a 62-step serial divide for the time ratio and four 31-step serial
// multiplies for the powers (both skipped for a zero duration), then one per blended joint.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset (arst_n low): registers at defaults, poses, durations and time cleared, no result.
`default_nettype none
module quintic_joint_trajectory import qjt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire qjt_in_t     in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output qjt_out_t         out_data,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	typedef enum logic [14:0] {
		ST_IDLE   = 15'b000000000000001,
		ST_TRAV   = 15'b000000000000010,
		ST_TDIV   = 15'b000000000000100,
		ST_TUPD   = 15'b000000000001000,
		ST_TICK   = 15'b000000000010000,
		ST_SMOOTH = 15'b000000000100000,
		ST_UDIV   = 15'b000000001000000,
		ST_PMUL   = 15'b000000010000000,
		ST_PWAIT  = 15'b000000100000000,
		ST_POLY   = 15'b000001000000000,
		ST_SCLAMP = 15'b000010000000000,
		ST_BLEND  = 15'b000100000000000,
		ST_BWAIT  = 15'b001000000000000,
		ST_TIME   = 15'b010000000000000,
		ST_OUT    = 15'b100000000000000
	} state_t;

	state_t state_q;

	logic signed [31:0] tilt_q;
	logic               coord_q;
	logic [31:0]        speed_q;
	logic [15:0]        period_q;

	logic [31:0] start_q [JOINTS];
	logic [31:0] goal_q  [JOINTS];
	logic [31:0] cur_q   [JOINTS];
	logic [31:0] jdur_q  [JOINTS];
	logic [31:0] longest_q;
	logic [31:0] elapsed_q;
	logic [JW-1:0] active_q;

	logic [JW-1:0] k_q;
	logic          all_q;
	logic [31:0]   dur_q;
	logic [1:0]    pcnt_q;
	logic [30:0]   u_q;
	logic [30:0]   pw_q;
	logic [30:0]   u3_q;
	logic [30:0]   u4_q;
	logic [30:0]   u5_q;
	logic [34:0]   pos_q;
	logic [34:0]   neg_q;
	logic [30:0]   s_q;
	logic          moving_q;
	logic [1:0]    ret_q;

	logic     out_valid_q;
	qjt_out_t out_q;

	logic             div_start;
	logic [DIV_W-1:0] div_dividend;
	logic [31:0]      div_divisor;
	logic             div_done;
	logic [DIV_W-1:0] div_quot;

	logic              mul_start;
	logic [MUL_AW-1:0] mul_a;
	logic [MUL_BW-1:0] mul_b;
	logic              mul_done;
	logic [63:0]       mul_prod;

	logic        in_acc;
	logic        out_free;
	logic [32:0] diff;
	logic        diff_neg;
	logic [32:0] mag;
	logic [63:0] bsum;
	logic [31:0] bq;
	logic [32:0] esum;
	logic [34:0] pos_n;
	logic [34:0] neg_n;
	logic [34:0] sdiff;
	logic [30:0] u_n;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	// Travel of the selected joint
	assign diff     = {goal_q[k_q][31], goal_q[k_q]} - {start_q[k_q][31], start_q[k_q]};
	assign diff_neg = diff[32];
	assign mag      = diff_neg ? (33'd0 - diff) : diff;

	// Rounded blend term and saturating time update
	assign bsum = mul_prod + HALF_Q30;
	assign bq   = bsum[61:30];
	assign esum = {1'b0, elapsed_q} + {17'd0, period_q};

	// Polynomial terms by shift and add
	assign pos_n = ({4'd0, u3_q} << 3) + ({4'd0, u3_q} << 1)
		+ ({4'd0, u5_q} << 2) + ({4'd0, u5_q} << 1);
	assign neg_n = ({4'd0, u4_q} << 4) - {4'd0, u4_q};
	assign sdiff = pos_q - neg_q;
	assign u_n   = (div_quot > {31'd0, ONE_Q30}) ? ONE_Q30 : div_quot[30:0];

	// Drive the serial units
	always_comb begin
		div_start    = 1'b0;
		div_dividend = {13'd0, mag, 16'd0};
		div_divisor  = speed_q;
		mul_start    = 1'b0;
		mul_a        = {2'b00, pw_q};
		mul_b        = u_q;
		case (state_q)
			ST_TRAV: begin
				div_start = (speed_q != 32'd0);
			end
			ST_SMOOTH: begin
				div_start    = (dur_q != 32'd0);
				div_dividend = {elapsed_q, 30'd0};
				div_divisor  = dur_q;
			end
			ST_PMUL: begin
				mul_start = 1'b1;
			end
			ST_BLEND: begin
				mul_start = 1'b1;
				mul_a     = mag;
				mul_b     = s_q;
			end
			default: begin
			end
		endcase
	end

	qjt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot)
	);

	qjt_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_q   <= '0;
			coord_q  <= 1'b1;
			speed_q  <= 32'd65536;
			period_q <= 16'd13107;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TILT:   tilt_q   <= cfg_data;
				REG_COORD:  coord_q  <= cfg_data[0];
				REG_SPEED:  speed_q  <= cfg_data;
				REG_PERIOD: period_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer and move state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			longest_q   <= '0;
			elapsed_q   <= '0;
			active_q    <= '0;
			k_q         <= '0;
			all_q       <= 1'b0;
			dur_q       <= '0;
			pcnt_q      <= '0;
			u_q         <= '0;
			pw_q        <= '0;
			u3_q        <= '0;
			u4_q        <= '0;
			u5_q        <= '0;
			pos_q       <= '0;
			neg_q       <= '0;
			s_q         <= '0;
			moving_q    <= 1'b0;
			ret_q       <= RET_INIT;
			for (int i = 0; i < JOINTS; i++) begin
				start_q[i] <= '0;
				goal_q[i]  <= '0;
				cur_q[i]   <= '0;
				jdur_q[i]  <= '0;
			end
		end else begin
			// drop the result once taken, unless a new one loads now
			if (out_valid_q && out_ready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						moving_q <= 1'b1;
						if (in_data.func == FUNC_START) begin
							start_q[0] <= in_data.init_q1;
							start_q[1] <= in_data.init_q2;
							start_q[2] <= in_data.init_q3;
							start_q[3] <= in_data.init_q4;
							cur_q[0]   <= in_data.init_q1;
							cur_q[1]   <= in_data.init_q2;
							cur_q[2]   <= in_data.init_q3;
							cur_q[3]   <= in_data.init_q4;
							goal_q[0]  <= in_data.init_q1;
							goal_q[1]  <= in_data.init_q2;
							goal_q[2]  <= in_data.init_q3;
							goal_q[3]  <= tilt_q;
							active_q   <= '0;
							elapsed_q  <= '0;
							longest_q  <= '0;
							k_q        <= '0;
							ret_q      <= RET_INIT;
							state_q    <= ST_TRAV;
						end else begin
							ret_q   <= RET_RUN;
							state_q <= ST_TICK;
						end
					end
				end
				ST_TRAV: begin
					if (speed_q == 32'd0) begin
						jdur_q[k_q] <= (mag != 33'd0) ? 32'hFFFF_FFFF : 32'd0;
						state_q     <= ST_TUPD;
					end else begin
						state_q <= ST_TDIV;
					end
				end
				ST_TDIV: begin
					if (div_done) begin
						jdur_q[k_q] <= (div_quot[DIV_W-1:32] != '0) ? 32'hFFFF_FFFF
							: div_quot[31:0];
						state_q <= ST_TUPD;
					end
				end
				ST_TUPD: begin
					if (jdur_q[k_q] > longest_q) begin
						longest_q <= jdur_q[k_q];
					end
					k_q     <= k_q + 1'b1;
					state_q <= (k_q == JW'(JOINTS - 1)) ? ST_OUT : ST_TRAV;
				end
				ST_TICK: begin
					if (coord_q) begin
						if (elapsed_q <= longest_q) begin
							dur_q   <= longest_q;
							k_q     <= '0;
							all_q   <= 1'b1;
							state_q <= ST_SMOOTH;
						end else begin
							for (int i = 0; i < JOINTS; i++) cur_q[i] <= goal_q[i];
							moving_q <= 1'b0;
							ret_q    <= RET_OK;
							state_q  <= ST_TIME;
						end
					end else if (elapsed_q <= jdur_q[active_q]) begin
						dur_q   <= jdur_q[active_q];
						k_q     <= active_q;
						all_q   <= 1'b0;
						state_q <= ST_SMOOTH;
					end else if (active_q == JW'(JOINTS - 1)) begin
						for (int i = 0; i < JOINTS; i++) cur_q[i] <= goal_q[i];
						moving_q <= 1'b0;
						ret_q    <= RET_OK;
						state_q  <= ST_TIME;
					end else begin
						// advance to the next joint, restart its clock
						active_q  <= active_q + 1'b1;
						elapsed_q <= '0;
						state_q   <= ST_TIME;
					end
				end
				ST_SMOOTH: begin
					if (dur_q == 32'd0) begin
						s_q     <= ONE_Q30;
						state_q <= ST_BLEND;
					end else begin
						state_q <= ST_UDIV;
					end
				end
				ST_UDIV: begin
					if (div_done) begin
						u_q     <= u_n;
						pw_q    <= u_n;
						pcnt_q  <= '0;
						state_q <= ST_PMUL;
					end
				end
				ST_PMUL: begin
					state_q <= ST_PWAIT;
				end
				ST_PWAIT: begin
					if (mul_done) begin
						pw_q   <= mul_prod[60:30];
						pcnt_q <= pcnt_q + 2'd1;
						case (pcnt_q)
							2'd1: u3_q <= mul_prod[60:30];
							2'd2: u4_q <= mul_prod[60:30];
							2'd3: u5_q <= mul_prod[60:30];
							default: begin
							end
						endcase
						state_q <= (pcnt_q == 2'd3) ? ST_POLY : ST_PMUL;
					end
				end
				ST_POLY: begin
					pos_q   <= pos_n;
					neg_q   <= neg_n;
					state_q <= ST_SCLAMP;
				end
				ST_SCLAMP: begin
					if (pos_q <= neg_q) begin
						s_q <= '0;
					end else if (sdiff > {4'd0, ONE_Q30}) begin
						s_q <= ONE_Q30;
					end else begin
						s_q <= sdiff[30:0];
					end
					state_q <= ST_BLEND;
				end
				ST_BLEND: begin
					state_q <= ST_BWAIT;
				end
				ST_BWAIT: begin
					if (mul_done) begin
						cur_q[k_q] <= diff_neg ? (start_q[k_q] - bq) : (start_q[k_q] + bq);
						if (all_q && (k_q != JW'(JOINTS - 1))) begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_BLEND;
						end else begin
							state_q <= ST_TIME;
						end
					end
				end
				ST_TIME: begin
					elapsed_q <= esum[32] ? 32'hFFFF_FFFF : esum[31:0];
					state_q   <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_q.pose_q1        <= cur_q[0];
			out_q.pose_q2        <= cur_q[1];
			out_q.pose_q3        <= cur_q[2];
			out_q.pose_q4        <= cur_q[3];
			out_q.total_duration <= longest_q;
			out_q.moving         <= moving_q;
			out_q.action_ret     <= ret_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_TDIV || state_q == ST_UDIV))
		else $error("divider finished outside a divide wait");

	a_mul_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_PWAIT || state_q == ST_BWAIT))
		else $error("multiplier finished outside a multiply wait");

	a_standby_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.moving) |-> (out_data.action_ret == RET_OK))
		else $error("standby result without ok return");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("item accepted but sequencer stayed idle");

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none
module tb_top import qjt_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready;
	qjt_in_t in_data;
	logic out_valid, out_ready;
	qjt_out_t out_data;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	quintic_joint_trajectory uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	localparam logic [63:0] Q30_ONE = 64'h4000_0000;
	localparam logic [31:0] DUR_SAT = 32'hFFFF_FFFF;

	// shadow copy of the block's registers and state
	logic signed [31:0] tilt_goal;
	logic               coord_mode;
	logic [31:0]        speed_limit;
	logic [15:0]        tick_period;
	logic signed [31:0] pose_from [4];
	logic signed [31:0] pose_to [4];
	logic signed [31:0] pose_now [4];
	logic [31:0]        joint_time [4];
	logic [31:0]        move_time;
	logic [31:0]        time_spent;
	logic [1:0]         joint_sel;

	qjt_out_t pending_poses[$];
	int fail_count;
	longint cycle_count;
	int stall_left;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] joint_travel(logic signed [31:0] a, logic signed [31:0] b);
		longint d;
		logic [63:0] mag, q;
		d = longint'(b) - longint'(a);
		mag = d < 0 ? -d : d;
		if (speed_limit == 0) return mag != 0 ? DUR_SAT : 32'd0;
		q = (mag << 16) / speed_limit;
		return q > DUR_SAT ? DUR_SAT : q[31:0];
	endfunction

	function automatic logic [63:0] min_jerk(logic [31:0] t, logic [31:0] dur);
		logic [63:0] u, u2, u3, u4, u5, pos, neg, s;
		if (dur == 0) return Q30_ONE;
		u = ({32'd0, t} << 30) / dur;
		if (u > Q30_ONE) u = Q30_ONE;
		u2 = (u * u) >> 30;
		u3 = (u2 * u) >> 30;
		u4 = (u3 * u) >> 30;
		u5 = (u4 * u) >> 30;
		pos = 10 * u3 + 6 * u5;
		neg = 15 * u4;
		s = pos > neg ? pos - neg : 64'd0;
		return s > Q30_ONE ? Q30_ONE : s;
	endfunction

	function automatic logic signed [31:0] interp(logic signed [31:0] a, logic signed [31:0] b,
			logic [63:0] s);
		longint d;
		logic [63:0] mag, q;
		d = longint'(b) - longint'(a);
		mag = d < 0 ? -d : d;
		q = (mag * s + (Q30_ONE >> 1)) >> 30;
		return d < 0 ? 32'(longint'(a) - longint'(q)) : 32'(longint'(a) + longint'(q));
	endfunction

	task automatic reset_shadow();
		tilt_goal = 0; coord_mode = 1; speed_limit = 65536; tick_period = 13107;
		for (int i = 0; i < 4; i++) begin
			pose_from[i] = 0; pose_to[i] = 0; pose_now[i] = 0; joint_time[i] = 0;
		end
		move_time = 0; time_spent = 0; joint_sel = 0;
	endtask

	// advance the shadow state by one item and queue the expected pose
	task automatic predict_pose(qjt_in_t it);
		qjt_out_t r;
		logic [63:0] s, t;
		logic mv;
		logic [1:0] ret;
		mv = 1;
		if (it.func == FUNC_START) begin
			joint_sel = 0; time_spent = 0; move_time = 0;
			pose_from[0] = it.init_q1; pose_from[1] = it.init_q2;
			pose_from[2] = it.init_q3; pose_from[3] = it.init_q4;
			for (int i = 0; i < 4; i++) begin
				pose_now[i] = pose_from[i]; pose_to[i] = pose_from[i];
			end
			pose_to[3] = tilt_goal;
			for (int i = 0; i < 4; i++) begin
				joint_time[i] = joint_travel(pose_from[i], pose_to[i]);
				if (joint_time[i] > move_time) move_time = joint_time[i];
			end
			ret = RET_INIT;
		end else begin
			ret = RET_RUN;
			if (coord_mode) begin
				if (time_spent <= move_time) begin
					s = min_jerk(time_spent, move_time);
					for (int i = 0; i < 4; i++) pose_now[i] = interp(pose_from[i], pose_to[i], s);
				end else begin
					for (int i = 0; i < 4; i++) pose_now[i] = pose_to[i];
					mv = 0; ret = RET_OK;
				end
			end else if (time_spent <= joint_time[joint_sel]) begin
				s = min_jerk(time_spent, joint_time[joint_sel]);
				pose_now[joint_sel] = interp(pose_from[joint_sel], pose_to[joint_sel], s);
			end else if (joint_sel == 3) begin
				for (int i = 0; i < 4; i++) pose_now[i] = pose_to[i];
				mv = 0; ret = RET_OK;
			end else begin
				joint_sel = joint_sel + 1;
				time_spent = 0;
			end
			t = time_spent + tick_period;
			time_spent = t > DUR_SAT ? DUR_SAT : t[31:0];
		end
		r.pose_q1 = pose_now[0]; r.pose_q2 = pose_now[1];
		r.pose_q3 = pose_now[2]; r.pose_q4 = pose_now[3];
		r.total_duration = move_time; r.moving = mv; r.action_ret = ret;
		pending_poses.push_back(r);
	endtask

	function automatic int pick_gap();
		int k;
		k = $urandom_range(0, 99);
		if (k < 55) return 0;
		if (k < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// send one item and record its expectation at acceptance
	task automatic send_item(qjt_in_t it);
		repeat (pick_gap()) @(posedge clk);
		in_valid <= 1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		predict_pose(it);
		in_valid <= 0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_poses.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			REG_TILT:   tilt_goal = val;
			REG_COORD:  coord_mode = val[0];
			REG_SPEED:  speed_limit = val;
			REG_PERIOD: tick_period = val[15:0];
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	function automatic qjt_in_t start_item(logic [31:0] a, logic [31:0] b, logic [31:0] c,
			logic [31:0] d);
		qjt_in_t it;
		it.func = FUNC_START;
		it.init_q1 = a; it.init_q2 = b; it.init_q3 = c; it.init_q4 = d;
		return it;
	endfunction

	function automatic qjt_in_t tick_item();
		qjt_in_t it;
		it = start_item($urandom, $urandom, $urandom, $urandom);
		it.func = FUNC_TICK;
		return it;
	endfunction

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		qjt_out_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_poses.size() == 0) begin
				$error("result with no expectation: %h", out_data);
				fail_count++;
			end else begin
				e = pending_poses.pop_front();
				if (out_data.pose_q1 !== e.pose_q1) begin
					$error("pose_q1 exp %h got %h", e.pose_q1, out_data.pose_q1); fail_count++;
				end
				if (out_data.pose_q2 !== e.pose_q2) begin
					$error("pose_q2 exp %h got %h", e.pose_q2, out_data.pose_q2); fail_count++;
				end
				if (out_data.pose_q3 !== e.pose_q3) begin
					$error("pose_q3 exp %h got %h", e.pose_q3, out_data.pose_q3); fail_count++;
				end
				if (out_data.pose_q4 !== e.pose_q4) begin
					$error("pose_q4 exp %h got %h", e.pose_q4, out_data.pose_q4); fail_count++;
				end
				if (out_data.total_duration !== e.total_duration) begin
					$error("total_duration exp %h got %h", e.total_duration,
						out_data.total_duration);
					fail_count++;
				end
				if (out_data.moving !== e.moving) begin
					$error("moving exp %b got %b", e.moving, out_data.moving); fail_count++;
				end
				if (out_data.action_ret !== e.action_ret) begin
					$error("action_ret exp %0d got %0d", e.action_ret, out_data.action_ret);
					fail_count++;
				end
			end
		end
	end

	// stall the result side at random, mostly short and now and then long
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1;
			stall_left = 0;
		end else if (stall_left > 0) begin
			out_ready <= 0;
			stall_left--;
		end else if ($urandom_range(0, 99) < 15) begin
			out_ready <= 0;
			stall_left = pick_gap();
		end else begin
			out_ready <= 1;
		end
	end

	// end the run if it hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 3000000) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// tick before any start, then boundary poses
	task automatic test_directed();
		send_item(tick_item());
		wait_drained();
		write_reg(REG_TILT, 32'h7FFF_FFFF);
		send_item(start_item(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h8000_0000));
		repeat (3) send_item(tick_item());
		wait_drained();
		write_reg(REG_SPEED, 32'hFFFF_FFFF);
		write_reg(REG_PERIOD, 32'h0000_FFFF);
		send_item(start_item(32'hFFFF_FFFF, 1, 32'h1234_5678, 32'h0001_0000));
		repeat (4) send_item(tick_item());
		wait_drained();
		// zero travel: duration zero, goal at once
		write_reg(REG_TILT, 32'h0002_0000);
		send_item(start_item(5, 6, 7, 32'h0002_0000));
		repeat (2) send_item(tick_item());
		wait_drained();
		// overflow of the duration saturates and never finishes
		write_reg(REG_SPEED, 1);
		write_reg(REG_TILT, 32'h8000_0000);
		send_item(start_item(0, 0, 0, 32'h7FFF_FFFF));
		repeat (3) send_item(tick_item());
		wait_drained();
	endtask

	// random moves in both modes with short and long durations
	task automatic test_random_moves(int n_items);
		int sent;
		sent = 0;
		while (sent < n_items) begin
			wait_drained();
			write_reg(REG_COORD, $urandom_range(0, 1));
			write_reg(REG_SPEED, $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1, 8) << 20);
			write_reg(REG_PERIOD, $urandom_range(0, 9) == 0 ? $urandom_range(1, 65535) :
				$urandom_range(8000, 40000));
			write_reg(REG_TILT, $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 1) << 22);
			send_item(start_item($urandom_range(0, 3) << 20, $urandom_range(0, 3) << 20,
				$urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 3) << 20, $urandom));
			sent++;
			for (int k = $urandom_range(5, 40); k > 0; k--) begin
				if ($urandom_range(0, 49) == 0) begin
					send_item(start_item($urandom, $urandom, $urandom, $urandom));
				end else begin
					send_item(tick_item());
				end
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_valid = 0;
		cfg_index = REG_TILT;
		cfg_data = 0;
		fail_count = 0;
		cycle_count = 0;
		reset_shadow();
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_random_moves(1100);
		wait_drained();
		repeat (600) @(posedge clk);
		if (fail_count == 0 && pending_poses.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* sim.f */
rtl/qjt_pkg.sv
rtl/qjt_div.sv
rtl/qjt_mul.sv
rtl/quintic_joint_trajectory.sv
tb/sv/tb_top.sv
